### rtl/core/dawd_pkg.sv
package dawd_pkg;

	// input word layout
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 14;
	localparam int ADD_W   = 16;
	localparam int WDAY_W  = 3;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;

	// usable offset bits
	localparam int OFFSET_BITS = 16;
	localparam int OFF_W = (OFFSET_BITS < ADD_W) ? OFFSET_BITS : ADD_W;
	// running day count: day plus offset, one bit of headroom
	localparam int RD_W = ((OFF_W > DAY_W) ? OFF_W : DAY_W) + 1;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// weekday arithmetic
	localparam int YY_W     = YEAR_W + 1;
	localparam int CENT_W   = 8;
	localparam int YR_W     = 7;
	localparam int WSUM_W   = 11;
	localparam int Q7_W     = 9;
	localparam int YEAR_BIAS    = 400;
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;
	localparam int DIV7_MUL     = 2341;
	localparam int DIV7_SHIFT   = 14;

	// cycles from accept until the weekday pipeline output is settled
	localparam int WAIT_W = 2;
	localparam logic [WAIT_W-1:0] WDAY_WAIT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOP,
		ST_DONE
	} dawd_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} dawd_step_ctrl_t;

endpackage

### rtl/core/date_add_days_weekday_unit.sv
// latency: grows with n, the number of months stepped over (n = 0 for a bad date, which
// only waits on the weekday pipeline); the result is registered once the loop is done
// throughput: one word at a time, set by the month loop doing one month per cycle
// in the shared subtract and compare unit; about 2150 months for the largest offset
// reset: arst_n asynchronous active low, clears the sequencer and the output valid
// no memories, so no clearing pass after reset
module date_add_days_weekday_unit import dawd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// month_in [3:0], day_in [8:4], year_in [22:9], add_days [38:23], zero fill
	input  logic [S_DATA_W-1:0]   s_tdata,
	// output channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// month_out [3:0], day_out [8:4], year_out [22:9], weekday [25:23], zero fill
	output logic [M_DATA_W-1:0]   m_tdata,
	// bad_date [0]
	output logic [0:0]            m_tuser
);

	// input word fields
	logic [MONTH_W-1:0] month_in;
	logic [DAY_W-1:0]   day_in;
	logic [YEAR_W-1:0]  year_in;
	logic [ADD_W-1:0]   add_days;

	assign month_in = s_tdata[3:0];
	assign day_in   = s_tdata[8:4];
	assign year_in  = s_tdata[22:9];
	assign add_days = s_tdata[38:23];

	dawd_state_t        state_q, state_d;
	dawd_step_ctrl_t    step_ctrl;
	logic [WAIT_W-1:0]  wait_q;
	logic               bad_q;
	logic               accept;
	logic               in_bad;
	logic               go_out;
	logic               fits;

	logic [MONTH_W-1:0] step_month;
	logic [DAY_W-1:0]   step_day;
	logic [YEAR_W-1:0]  step_year;
	logic [WDAY_W-1:0]  wday;

	logic               m_tvalid_q;
	logic [MONTH_W-1:0] month_out_q;
	logic [DAY_W-1:0]   day_out_q;
	logic [YEAR_W-1:0]  year_out_q;
	logic [WDAY_W-1:0]  weekday_q;
	logic               bad_out_q;

	// busy for the whole item; the output register lets the next word in
	// while a finished result still waits
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_bad   = (month_in < MONTH_JAN) || (month_in > MONTH_DEC) || (day_in == '0);

	// month walker: one month length subtracted per cycle
	dawd_month_step u_step (
		.clk      (clk),
		.ctrl     (step_ctrl),
		.month_ld (month_in),
		.day_ld   (day_in),
		.year_ld  (year_in),
		.offs_ld  (add_days[OFF_W-1:0]),
		.month    (step_month),
		.day      (step_day),
		.year     (step_year),
		.fits     (fits)
	);

	// weekday of the start date, three register stages
	dawd_weekday u_wday (
		.clk     (clk),
		.load    (accept),
		.month   (month_in),
		.day     (day_in),
		.year    (year_in),
		.weekday (wday)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		step_ctrl.load = 1'b0;
		step_ctrl.step = 1'b0;
		// result leaves once the weekday is settled and the output slot is free
		go_out = (state_q == ST_DONE) && (wait_q == '0) && (!m_tvalid_q || m_tready);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					step_ctrl.load = 1'b1;
					state_d = in_bad ? ST_DONE : ST_LOOP;
				end
			end
			ST_LOOP: begin
				// rolls over while the day count exceeds the month
				if (fits) begin
					state_d = ST_DONE;
				end else begin
					step_ctrl.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (go_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// weekday settle count and bad flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			bad_q  <= 1'b0;
		end else if (accept) begin
			wait_q <= WDAY_WAIT;
			bad_q  <= in_bad;
		end else if (wait_q != '0) begin
			wait_q <= wait_q - 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (go_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out) begin
			// a bad date gives all-zero fields
			month_out_q <= bad_q ? '0 : step_month;
			day_out_q   <= bad_q ? '0 : step_day;
			year_out_q  <= bad_q ? '0 : step_year;
			weekday_q   <= bad_q ? '0 : wday;
			bad_out_q   <= bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, weekday_q, year_out_q, day_out_q, month_out_q};
	assign m_tuser  = bad_out_q;

endmodule

### rtl/core/dawd_month_step.sv
module dawd_month_step import dawd_pkg::*; (
	input  logic                 clk,
	input  dawd_step_ctrl_t      ctrl,
	input  logic [MONTH_W-1:0]   month_ld,
	input  logic [DAY_W-1:0]     day_ld,
	input  logic [YEAR_W-1:0]    year_ld,
	input  logic [OFF_W-1:0]     offs_ld,
	output logic [MONTH_W-1:0]   month,
	output logic [DAY_W-1:0]     day,
	output logic [YEAR_W-1:0]    year,
	output logic                 fits
);

	logic [MONTH_W-1:0] rm_q;
	logic [RD_W-1:0]    rd_q;
	logic [YEAR_W-1:0]  ry_q;
	logic [DAY_W-1:0]   len;
	logic [RD_W:0]      diff;

	// days in the current month, leap when year divisible by four
	always_comb begin
		unique case (rm_q)
			4'd2:                      len = (ry_q[1:0] == 2'd0) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
	end

	// one subtractor does both compare and reduction
	assign diff = {1'b0, rd_q} - (RD_W+1)'(len);
	assign fits = diff[RD_W] || (diff == '0);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rm_q <= month_ld;
			rd_q <= RD_W'(day_ld) + RD_W'(offs_ld);
			ry_q <= year_ld;
		end else if (ctrl.step) begin
			rd_q <= diff[RD_W-1:0];
			if (rm_q >= MONTH_DEC) begin
				rm_q <= MONTH_JAN;
				ry_q <= ry_q + 1'b1;
			end else begin
				rm_q <= rm_q + 1'b1;
			end
		end
	end

	assign month = rm_q;
	assign day   = rd_q[DAY_W-1:0];
	assign year  = ry_q;

endmodule

### rtl/core/dawd_weekday.sv
module dawd_weekday import dawd_pkg::*; (
	input  logic                 clk,
	input  logic                 load,
	input  logic [MONTH_W-1:0]   month,
	input  logic [DAY_W-1:0]     day,
	input  logic [YEAR_W-1:0]    year,
	output logic [WDAY_W-1:0]    weekday
);

	function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
		logic [5:0] t;
		unique case (m)
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

	logic                 jan_feb;
	logic [MONTH_W-1:0]   mm;
	logic [YY_W-1:0]      yy;
	logic [27:0]          cent_prod;

	logic [YY_W-1:0]      yy_s1;
	logic [CENT_W-1:0]    cent_s1;
	logic [5:0]           mterm_s1;
	logic [DAY_W-1:0]     day_s1;

	logic [YY_W-1:0]      k_full;
	logic [YR_W-1:0]      k;
	logic [WSUM_W-1:0]    sum;
	logic [WSUM_W-1:0]    sum_s2;

	logic [22:0]          q_prod;
	logic [WSUM_W-1:0]    sum_s3;
	logic [Q7_W-1:0]      q_s3;
	logic [WSUM_W-1:0]    rem;

	// jan and feb count as months 13 and 14 of the year before
	assign jan_feb = (month == MONTH_JAN) || (month == MONTH_FEB);
	assign mm = jan_feb ? month + 4'd12 : month;
	assign yy = YY_W'(year) + YY_W'(YEAR_BIAS) - YY_W'(jan_feb);
	// century by reciprocal multiply
	assign cent_prod = 28'(yy) * 28'(DIV100_MUL);

	always_ff @(posedge clk) begin
		if (load) begin
			yy_s1    <= yy;
			cent_s1  <= cent_prod[DIV100_SHIFT +: CENT_W];
			mterm_s1 <= month_term(mm);
			day_s1   <= day;
		end
	end

	assign k_full = yy_s1 - YY_W'(cent_s1) * YY_W'(100);
	assign k = k_full[YR_W-1:0];
	assign sum = WSUM_W'(day_s1) + WSUM_W'(mterm_s1) + WSUM_W'(k) + WSUM_W'(k >> 2)
		+ WSUM_W'(cent_s1 >> 2) + WSUM_W'(cent_s1) * WSUM_W'(5);

	// mod 7 by reciprocal multiply
	assign q_prod = 23'(sum_s2) * 23'(DIV7_MUL);

	always_ff @(posedge clk) begin
		sum_s2 <= sum;
		sum_s3 <= sum_s2;
		q_s3   <= q_prod[DIV7_SHIFT +: Q7_W];
	end

	assign rem = sum_s3 - WSUM_W'(q_s3) * WSUM_W'(7);
	assign weekday = rem[WDAY_W-1:0];

endmodule

### rtl/core/dawd_checker.sv
module dawd_checker import dawd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,
	input  logic [0:0]            m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// bad date gives zero fields
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("bad date with nonzero fields");

	// good date gives an in-range result
	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[3:0] >= 4'd1) && (m_tdata[3:0] <= 4'd12)
		&& (m_tdata[8:4] != 5'd0) && (m_tdata[25:23] <= 3'd6))
		else $error("result fields out of range");

endmodule

bind date_add_days_weekday_unit dawd_checker u_dawd_checker (.*);
